/* rtl/rtfr_pkg.sv */
package rtfr_pkg;

	localparam int POLY_ORDER = 3;
	localparam int NCOEF      = 4;
	localparam int NREG       = 2 * NCOEF;
	localparam int IDX_W      = $clog2(NREG);
	localparam int QBITS      = 33;

	localparam logic [IDX_W-1:0] REG_NUM0 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_DEN0 = IDX_W'(NCOEF);

	typedef logic signed [31:0] word_t;

	localparam word_t COEF_ONE = 32'sh0001_0000;
	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
	localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

	typedef struct packed {
		word_t v;
		logic  sat;
	} clip_t;

	// sideband that rides along with the polynomial stages
	typedef struct packed {
		word_t xr;
		word_t xi;
		word_t g;
		logic  sat;
	} side_t;

	// sideband after the quotient
	typedef struct packed {
		word_t xr;
		word_t xi;
		word_t g;
		logic  sat;
		logic  dz;
		logic  qsat;
	} qside_t;

	function automatic clip_t clip32(input logic signed [65:0] v);
		clip_t r;
		if (v > WIDE_MAX) begin
			r.v   = WORD_MAX;
			r.sat = 1'b1;
		end else if (v < WIDE_MIN) begin
			r.v   = WORD_MIN;
			r.sat = 1'b1;
		end else begin
			r.v   = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/rtfr_cfg.sv */
module rtfr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rtfr_pkg::IDX_W-1:0]     wr_idx,
	input  logic [31:0]                    wr_data,
	output rtfr_pkg::word_t                num [rtfr_pkg::NCOEF],
	output rtfr_pkg::word_t                den [rtfr_pkg::NCOEF]
);

	rtfr_pkg::word_t regs_q [rtfr_pkg::NREG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rtfr_pkg::NREG; i++) begin
				regs_q[i] <= (i == rtfr_pkg::REG_NUM0 || i == rtfr_pkg::REG_DEN0) ?
					rtfr_pkg::COEF_ONE : '0;
			end
		end else if (wr_en) begin
			regs_q[wr_idx] <= wr_data;
		end
	end

	// coefficients above the polynomial order read as zero
	always_comb begin
		for (int k = 0; k < rtfr_pkg::NCOEF; k++) begin
			num[k] = (k <= rtfr_pkg::POLY_ORDER) ? regs_q[k] : '0;
			den[k] = (k <= rtfr_pkg::POLY_ORDER) ? regs_q[rtfr_pkg::NCOEF + k] : '0;
		end
	end

endmodule

/* rtl/rtfr_poly.sv */
module rtfr_poly (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [30:0]       omega,
	input  rtfr_pkg::word_t   in_re,
	input  rtfr_pkg::word_t   in_im,
	input  rtfr_pkg::word_t   gain,
	input  rtfr_pkg::word_t   num [rtfr_pkg::NCOEF],
	input  rtfr_pkg::word_t   den [rtfr_pkg::NCOEF],
	output logic              vld_out,
	output rtfr_pkg::word_t   nr,
	output rtfr_pkg::word_t   ni,
	output rtfr_pkg::word_t   dr,
	output rtfr_pkg::word_t   di,
	output rtfr_pkg::side_t   side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [30:0]             w_s1, w_s2;
	logic [61:0]             ww_s1;
	rtfr_pkg::side_t         sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6;
	logic [30:0]             w2_s2;
	logic                    f2_s2;
	logic [61:0]             w3p_s3;
	logic signed [63:0]      pn1_s3, pd1_s3, pn2_s3, pd2_s3;
	logic [30:0]             w3_s4;
	logic signed [47:0]      an1_s4, ad1_s4, an1_s5, ad1_s5;
	rtfr_pkg::word_t         nr_s4, dr_s4, nr_s5, dr_s5, nr_s6, dr_s6, ni_s6, di_s6;
	logic signed [63:0]      pn3_s5, pd3_s5;

	logic [45:0]             t2, t3;
	logic signed [31:0]      ws2, ws3;
	logic signed [47:0]      bn2, bd2, bn3, bd3;
	rtfr_pkg::clip_t         cnr, cdr, cni, cdi;
	logic                    f3;
	logic [30:0]             w3;

	assign t2  = ww_s1[61:16];
	assign t3  = w3p_s3[61:16];
	assign ws2 = $signed({1'b0, w_s2});
	assign ws3 = $signed({1'b0, w3_s4});
	assign bn2 = $signed(pn2_s3[63:16]);
	assign bd2 = $signed(pd2_s3[63:16]);
	assign bn3 = $signed(pn3_s5[63:16]);
	assign bd3 = $signed(pd3_s5[63:16]);
	assign f3  = |t3[45:31];
	assign w3  = f3 ? 31'h7FFF_FFFF : t3[30:0];
	assign cnr = rtfr_pkg::clip32(66'(num[0]) - 66'(bn2));
	assign cdr = rtfr_pkg::clip32(66'(den[0]) - 66'(bd2));
	assign cni = rtfr_pkg::clip32(66'(an1_s5) - 66'(bn3));
	assign cdi = rtfr_pkg::clip32(66'(ad1_s5) - 66'(bd3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// omega squared
			w_s1   <= omega;
			ww_s1  <= omega * omega;
			sd_s1  <= '{xr: in_re, xi: in_im, g: gain, sat: 1'b0};
			// clip w^2
			w_s2   <= w_s1;
			w2_s2  <= (|t2[45:31]) ? 31'h7FFF_FFFF : t2[30:0];
			f2_s2  <= |t2[45:31];
			sd_s2  <= sd_s1;
			// w^3 and first and second order terms
			w3p_s3 <= w2_s2 * w_s2;
			pn1_s3 <= num[1] * ws2;
			pd1_s3 <= den[1] * ws2;
			pn2_s3 <= num[2] * $signed({1'b0, w2_s2});
			pd2_s3 <= den[2] * $signed({1'b0, w2_s2});
			sd_s3  <= '{xr: sd_s2.xr, xi: sd_s2.xi, g: sd_s2.g,
				sat: sd_s2.sat | ((rtfr_pkg::POLY_ORDER >= 2) && f2_s2)};
			// real parts, clip w^3
			w3_s4  <= w3;
			an1_s4 <= $signed(pn1_s3[63:16]);
			ad1_s4 <= $signed(pd1_s3[63:16]);
			nr_s4  <= cnr.v;
			dr_s4  <= cdr.v;
			sd_s4  <= '{xr: sd_s3.xr, xi: sd_s3.xi, g: sd_s3.g,
				sat: sd_s3.sat | ((rtfr_pkg::POLY_ORDER >= 3) && f3) | cnr.sat | cdr.sat};
			// third order terms
			pn3_s5 <= num[3] * ws3;
			pd3_s5 <= den[3] * ws3;
			an1_s5 <= an1_s4;
			ad1_s5 <= ad1_s4;
			nr_s5  <= nr_s4;
			dr_s5  <= dr_s4;
			sd_s5  <= sd_s4;
			// imaginary parts
			nr_s6  <= nr_s5;
			dr_s6  <= dr_s5;
			ni_s6  <= cni.v;
			di_s6  <= cdi.v;
			sd_s6  <= '{xr: sd_s5.xr, xi: sd_s5.xi, g: sd_s5.g,
				sat: sd_s5.sat | cni.sat | cdi.sat};
		end
	end

	assign vld_out = v_s6;
	assign nr      = nr_s6;
	assign ni      = ni_s6;
	assign dr      = dr_s6;
	assign di      = di_s6;
	assign side    = sd_s6;

endmodule

/* rtl/rtfr_quot.sv */
module rtfr_quot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  rtfr_pkg::word_t   nr,
	input  rtfr_pkg::word_t   ni,
	input  rtfr_pkg::word_t   dr,
	input  rtfr_pkg::word_t   di,
	input  rtfr_pkg::side_t   side,
	output logic              vld_out,
	output rtfr_pkg::word_t   qr,
	output rtfr_pkg::word_t   qi,
	output rtfr_pkg::qside_t  qside
);

	localparam int QB = rtfr_pkg::QBITS;
	localparam int SH = QB - 16;

	logic v_s7, v_s8, v_s9;
	logic signed [63:0] nrdr_s7, nidi_s7, nidr_s7, nrdi_s7, drdr_s7, didi_s7;
	rtfr_pkg::side_t    sd_s7, sd_s8, sd_s9;
	logic signed [64:0] sr_s8, si_s8;
	logic [63:0]        den_s8, den_s9;
	logic [63:0]        mr_s9, mi_s9;
	logic               ngr_s9, ngi_s9, dz_s9;

	// division steps: index 0 is the entry stage
	logic               vst_s  [QB+1];
	logic [63:0]        dst_s  [QB+1];
	rtfr_pkg::side_t    sst_s  [QB+1];
	logic               zst_s  [QB+1];
	logic [63:0]        rem_s  [2][QB+1];
	logic [QB-1:0]      low_s  [2][QB+1];
	logic [QB-1:0]      quo_s  [2][QB+1];
	logic               big_s  [2][QB+1];
	logic               neg_s  [2][QB+1];

	logic               vf_s;
	rtfr_pkg::word_t    qr_sf, qi_sf;
	rtfr_pkg::qside_t   qs_sf;

	logic [63:0]        mag_in [2];
	logic               neg_in [2];
	rtfr_pkg::clip_t    fin    [2];

	assign mag_in[0] = mr_s9;
	assign mag_in[1] = mi_s9;
	assign neg_in[0] = ngr_s9;
	assign neg_in[1] = ngi_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= vld_in;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrdr_s7 <= nr * dr;
			nidi_s7 <= ni * di;
			nidr_s7 <= ni * dr;
			nrdi_s7 <= nr * di;
			drdr_s7 <= dr * dr;
			didi_s7 <= di * di;
			sd_s7   <= side;
			// n * conj(d) and |d|^2
			sr_s8   <= 65'(nrdr_s7) + 65'(nidi_s7);
			si_s8   <= 65'(nidr_s7) - 65'(nrdi_s7);
			den_s8  <= $unsigned(drdr_s7) + $unsigned(didi_s7);
			sd_s8   <= sd_s7;
			// magnitudes and signs
			mr_s9   <= sr_s8[64] ? 64'(-sr_s8) : sr_s8[63:0];
			mi_s9   <= si_s8[64] ? 64'(-si_s8) : si_s8[63:0];
			ngr_s9  <= sr_s8[64];
			ngi_s9  <= si_s8[64];
			den_s9  <= den_s8;
			dz_s9   <= (den_s8 == '0);
			sd_s9   <= sd_s8;
		end
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vst_s[0] <= 1'b0;
		end else if (en) begin
			vst_s[0] <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s[0] <= den_s9;
			sst_s[0] <= sd_s9;
			zst_s[0] <= dz_s9;
		end
	end

	genvar k, m;
	generate
		for (m = 0; m < 2; m++) begin : g_entry
			always_ff @(posedge clk) begin
				if (en) begin
					// dividend is mag * 2^16; quotient needs QB bits unless it overflows
					big_s[m][0] <= 64'(mag_in[m][63:SH]) >= den_s9;
					rem_s[m][0] <= 64'(mag_in[m][63:SH]);
					low_s[m][0] <= {mag_in[m][SH-1:0], 16'b0};
					quo_s[m][0] <= '0;
					neg_s[m][0] <= neg_in[m];
				end
			end
		end

		for (k = 1; k <= QB; k++) begin : g_step
			logic [64:0] t    [2];
			logic        ge   [2];
			logic [64:0] diff [2];

			always_comb begin
				for (int l = 0; l < 2; l++) begin
					t[l]    = {rem_s[l][k-1], low_s[l][k-1][QB-1]};
					diff[l] = t[l] - {1'b0, dst_s[k-1]};
					ge[l]   = t[l] >= {1'b0, dst_s[k-1]};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vst_s[k] <= 1'b0;
				end else if (en) begin
					vst_s[k] <= vst_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dst_s[k] <= dst_s[k-1];
					sst_s[k] <= sst_s[k-1];
					zst_s[k] <= zst_s[k-1];
				end
			end

			for (m = 0; m < 2; m++) begin : g_lane
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[m][k] <= ge[m] ? diff[m][63:0] : t[m][63:0];
						low_s[m][k] <= {low_s[m][k-1][QB-2:0], 1'b0};
						quo_s[m][k] <= {quo_s[m][k-1][QB-2:0], ge[m]};
						big_s[m][k] <= big_s[m][k-1];
						neg_s[m][k] <= neg_s[m][k-1];
					end
				end
			end
		end
	endgenerate

	// sign and clip of both quotients
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (neg_s[l][QB]) begin
				if (big_s[l][QB] || (quo_s[l][QB] > {1'b0, 32'h8000_0000})) begin
					fin[l] = '{v: rtfr_pkg::WORD_MIN, sat: 1'b1};
				end else begin
					fin[l] = '{v: 32'(-quo_s[l][QB]), sat: 1'b0};
				end
			end else begin
				if (big_s[l][QB] || (|quo_s[l][QB][QB-1:31])) begin
					fin[l] = '{v: rtfr_pkg::WORD_MAX, sat: 1'b1};
				end else begin
					fin[l] = '{v: quo_s[l][QB][31:0], sat: 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_s <= 1'b0;
		end else if (en) begin
			vf_s <= vst_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_sf <= fin[0].v;
			qi_sf <= fin[1].v;
			qs_sf <= '{xr: sst_s[QB].xr, xi: sst_s[QB].xi, g: sst_s[QB].g,
				sat: sst_s[QB].sat, dz: zst_s[QB], qsat: fin[0].sat | fin[1].sat};
		end
	end

	assign vld_out = vf_s;
	assign qr      = qr_sf;
	assign qi      = qi_sf;
	assign qside   = qs_sf;

endmodule

/* rtl/rtfr_out.sv */
module rtfr_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  rtfr_pkg::word_t   qr,
	input  rtfr_pkg::word_t   qi,
	input  rtfr_pkg::qside_t  qside,
	output logic              vld_out,
	output rtfr_pkg::word_t   out_re,
	output rtfr_pkg::word_t   out_im,
	output logic              div_zero,
	output logic              saturated
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] prr_s1, pii_s1, pri_s1, pir_s1;
	rtfr_pkg::qside_t   qs_s1, qs_s2, qs_s3;
	rtfr_pkg::word_t    yr_s2, yi_s2;
	logic signed [63:0] gr_s3, gi_s3;
	rtfr_pkg::word_t    ore_s4, oim_s4;
	logic               dz_s4, sat_s4;

	logic signed [47:0] brr, bii, bri, bir, bgr, bgi;
	rtfr_pkg::clip_t    cyr, cyi, cor, coi;

	assign brr = $signed(prr_s1[63:16]);
	assign bii = $signed(pii_s1[63:16]);
	assign bri = $signed(pri_s1[63:16]);
	assign bir = $signed(pir_s1[63:16]);
	assign bgr = $signed(gr_s3[63:16]);
	assign bgi = $signed(gi_s3[63:16]);
	assign cyr = rtfr_pkg::clip32(66'(brr) - 66'(bii));
	assign cyi = rtfr_pkg::clip32(66'(bri) + 66'(bir));
	assign cor = rtfr_pkg::clip32(66'(bgr));
	assign coi = rtfr_pkg::clip32(66'(bgi));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prr_s1 <= qr * qside.xr;
			pii_s1 <= qi * qside.xi;
			pri_s1 <= qr * qside.xi;
			pir_s1 <= qi * qside.xr;
			qs_s1  <= qside;
			yr_s2  <= cyr.v;
			yi_s2  <= cyi.v;
			qs_s2  <= '{xr: qs_s1.xr, xi: qs_s1.xi, g: qs_s1.g, sat: qs_s1.sat,
				dz: qs_s1.dz, qsat: qs_s1.qsat | cyr.sat | cyi.sat};
			gr_s3  <= yr_s2 * qs_s2.g;
			gi_s3  <= yi_s2 * qs_s2.g;
			qs_s3  <= qs_s2;
			// zero denominator keeps only the polynomial clips
			if (qs_s3.dz) begin
				ore_s4 <= '0;
				oim_s4 <= '0;
				sat_s4 <= qs_s3.sat;
			end else begin
				ore_s4 <= cor.v;
				oim_s4 <= coi.v;
				sat_s4 <= qs_s3.sat | qs_s3.qsat | cor.sat | coi.sat;
			end
			dz_s4 <= qs_s3.dz;
		end
	end

	assign vld_out   = v_s4;
	assign out_re    = ore_s4;
	assign out_im    = oim_s4;
	assign div_zero  = dz_s4;
	assign saturated = sat_s4;

endmodule

/* rtl/rational_tf_freq_response.sv */
// an accepted item passes rtfr_poly, rtfr_quot and rtfr_out on its way to the output register
// throughput: one item per cycle; the whole pipeline holds when the output waits
// the 33-step restoring divider (one quotient bit per stage) sets the depth
// reset clears all valid bits and loads num_coef0 and den_coef0 with 1.0,
// the other coefficients with zero
module rational_tf_freq_response (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [30:0]                 omega,
	input  logic signed [31:0]          in_re,
	input  logic signed [31:0]          in_im,
	input  logic signed [31:0]          gain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          out_re,
	output logic signed [31:0]          out_im,
	output logic                        div_zero,
	output logic                        saturated,
	input  logic                        wr_en,
	input  logic [rtfr_pkg::IDX_W-1:0]  wr_idx,
	input  logic [31:0]                 wr_data
);

	logic               en;
	rtfr_pkg::word_t    num [rtfr_pkg::NCOEF];
	rtfr_pkg::word_t    den [rtfr_pkg::NCOEF];
	logic               p_vld, q_vld;
	rtfr_pkg::word_t    nr, ni, dr, di, qr, qi;
	rtfr_pkg::side_t    side;
	rtfr_pkg::qside_t   qside;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	rtfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.num     (num),
		.den     (den)
	);

	rtfr_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.omega   (omega),
		.in_re   (in_re),
		.in_im   (in_im),
		.gain    (gain),
		.num     (num),
		.den     (den),
		.vld_out (p_vld),
		.nr      (nr),
		.ni      (ni),
		.dr      (dr),
		.di      (di),
		.side    (side)
	);

	rtfr_quot u_quot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (p_vld),
		.nr      (nr),
		.ni      (ni),
		.dr      (dr),
		.di      (di),
		.side    (side),
		.vld_out (q_vld),
		.qr      (qr),
		.qi      (qi),
		.qside   (qside)
	);

	rtfr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (q_vld),
		.qr        (qr),
		.qi        (qi),
		.qside     (qside),
		.vld_out   (out_valid),
		.out_re    (out_re),
		.out_im    (out_im),
		.div_zero  (div_zero),
		.saturated (saturated)
	);

endmodule

/* rtl/rtfr_chk.sv */
module rtfr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_re,
	input logic signed [31:0] out_im,
	input logic               div_zero
);

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im))
		else $error("result changed while stalled");

	// zero denominator gives zero outputs
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> out_re == 0 && out_im == 0)
		else $error("div_zero with nonzero output");

	// input side takes items whenever the output is free
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with free output");

endmodule

bind rational_tf_freq_response rtfr_chk u_chk (.*);

/* sim/rational_tf_freq_response_tb.sv */
`timescale 1ns / 100ps

module rational_tf_freq_response_tb;
	import rtfr_pkg::*;

	localparam int LATENCY    = 48;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		word_t re;
		word_t im;
		logic  dz;
		logic  sat;
	} resp_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [30:0]         omega;
	word_t               in_re;
	word_t               in_im;
	word_t               gain;
	logic                out_valid;
	logic                out_ready;
	word_t               out_re;
	word_t               out_im;
	logic                div_zero;
	logic                saturated;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [31:0]         wr_data;

	word_t coef [NREG];
	resp_t pending_resp [$];
	int    mismatches;
	int    quiet;
	int    hold_len;
	int    stall_cnt;

	rational_tf_freq_response DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.omega(omega), .in_re(in_re), .in_im(in_im), .gain(gain),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_re(out_re), .out_im(out_im), .div_zero(div_zero), .saturated(saturated),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clip_word(input longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic void poly_eval(input int base, input longint w, input longint w2,
			input longint w3, output longint re, output longint im, inout bit f);
		longint c [4];
		for (int k = 0; k < 4; k++)
			c[k] = (k > POLY_ORDER) ? 64'sd0 : longint'(coef[base + k]);
		re = clip_word(c[0] - ((c[2] * w2) >>> 16), f);
		im = clip_word(((c[1] * w) >>> 16) - ((c[3] * w3) >>> 16), f);
	endfunction

	// (a*b + c*d) * 2^16 / den, truncated toward zero
	function automatic longint cplx_quot(input longint a, input longint b, input longint c,
			input longint d, input logic [63:0] den, inout bit f);
		logic signed [127:0] s;
		logic [127:0]        mag;
		logic [127:0]        qq;
		longint              p1;
		longint              p2;
		bit                  neg;
		p1  = a * b;
		p2  = c * d;
		s   = p1;
		s   = s + p2;
		neg = s < 0;
		mag = neg ? -s : s;
		mag = mag << 16;
		qq  = mag / {64'd0, den};
		if (qq > (128'd1 << 40))
			qq = 128'd1 << 40;
		return clip_word(neg ? -longint'(qq) : longint'(qq), f);
	endfunction

	function automatic resp_t tf_response(input logic [30:0] w_in, input word_t xr_in,
			input word_t xi_in, input word_t g_in);
		resp_t       r;
		bit          sat;
		bit          f2;
		bit          f3;
		longint      w, xr, xi, g, w2, w3, nr, ni, dr, di, qr, qi, yr, yi;
		logic [63:0] den;
		sat = 0;
		f2  = 0;
		f3  = 0;
		w   = w_in;
		xr  = xr_in;
		xi  = xi_in;
		g   = g_in;
		w2  = clip_word((w * w) >>> 16, f2);
		w3  = clip_word((w2 * w) >>> 16, f3);
		if (POLY_ORDER >= 2 && f2)
			sat = 1;
		if (POLY_ORDER >= 3 && f3)
			sat = 1;
		poly_eval(0, w, w2, w3, nr, ni, sat);
		poly_eval(NCOEF, w, w2, w3, dr, di, sat);
		den  = 64'(dr * dr) + 64'(di * di);
		r.re = '0;
		r.im = '0;
		r.dz = den == 0;
		if (den != 0) begin
			qr   = cplx_quot(nr, dr, ni, di, den, sat);
			qi   = cplx_quot(ni, dr, -nr, di, den, sat);
			yr   = clip_word(((qr * xr) >>> 16) - ((qi * xi) >>> 16), sat);
			yi   = clip_word(((qr * xi) >>> 16) + ((qi * xr) >>> 16), sat);
			r.re = word_t'(clip_word((yr * g) >>> 16, sat));
			r.im = word_t'(clip_word((yi * g) >>> 16, sat));
		end
		r.sat = sat;
		return r;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(5))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return word_t'($urandom_range(0, 1 << 19)) - word_t'(1 << 18);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic logic [30:0] rand_omega();
		case ($urandom_range(3))
			0: return 31'($urandom);
			1: return 31'($urandom_range(0, 1 << 16));
			default: return 31'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_item(input logic [30:0] w, input word_t re, input word_t im,
			input word_t g);
		if (!quiet && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		omega    <= w;
		in_re    <= re;
		in_im    <= im;
		gain     <= g;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_resp.push_back(tf_response(w, re, im, g));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_coefs(input word_t nc [4], input word_t dc [4]);
		for (int k = 0; k < NREG; k++) begin
			wr_en   <= 1'b1;
			wr_idx  <= (k < NCOEF) ? REG_NUM0 + IDX_W'(k) : REG_DEN0 + IDX_W'(k - NCOEF);
			wr_data <= (k < NCOEF) ? nc[k] : dc[k - NCOEF];
			coef[k] = (k < NCOEF) ? nc[k] : dc[k - NCOEF];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic test_reset_values();
		send_item(31'd0, COEF_ONE, -COEF_ONE, COEF_ONE);
		send_item(31'h7FFF_FFFF, WORD_MAX, WORD_MIN, WORD_MAX);
		send_item(31'h0001_0000, WORD_MIN, WORD_MAX, WORD_MIN);
		send_item(31'h5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000);
		send_item(31'h2AAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, -32'sh0002_0000);
		drain();
	endtask

	task automatic test_directed_coefs();
		word_t nc [4];
		word_t dc [4];
		nc = '{COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE};
		dc = '{COEF_ONE, 32'sh0002_0000, COEF_ONE, 32'sh0000_4000};
		load_coefs(nc, dc);
		send_item(31'd0, COEF_ONE, COEF_ONE, COEF_ONE);
		send_item(31'h0001_0000, COEF_ONE, -COEF_ONE, 32'sh0003_0000);
		send_item(31'h0000_0100, WORD_MAX, WORD_MAX, WORD_MAX);
		send_item(31'h7FFF_FFFF, COEF_ONE, COEF_ONE, COEF_ONE);
		drain();
		// zero denominator everywhere
		dc = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
		load_coefs(nc, dc);
		send_item(31'd0, COEF_ONE, COEF_ONE, COEF_ONE);
		send_item(31'h7FFF_FFFF, WORD_MAX, WORD_MIN, WORD_MAX);
		send_item(31'h0003_0000, WORD_MIN, WORD_MIN, WORD_MIN);
		drain();
		// zero denominator only at dc
		dc = '{32'sd0, COEF_ONE, 32'sd0, 32'sd0};
		load_coefs(nc, dc);
		send_item(31'd0, COEF_ONE, COEF_ONE, COEF_ONE);
		send_item(31'h0000_0001, COEF_ONE, COEF_ONE, COEF_ONE);
		send_item(31'h0002_0000, COEF_ONE, COEF_ONE, COEF_ONE);
		drain();
		nc = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
		dc = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
		load_coefs(nc, dc);
		send_item(31'd0, WORD_MAX, WORD_MIN, WORD_MAX);
		send_item(31'h0001_0000, COEF_ONE, COEF_ONE, WORD_MIN);
		send_item(31'h7FFF_FFFF, WORD_MIN, WORD_MAX, WORD_MAX);
		nc = '{32'sd1, -32'sd1, 32'sd0, 32'sd0};
		drain();
		dc = '{WORD_MAX, 32'sd0, 32'sd0, 32'sd1};
		load_coefs(nc, dc);
		send_item(31'd0, WORD_MAX, WORD_MAX, WORD_MAX);
		send_item(31'h0000_8000, WORD_MIN, WORD_MIN, WORD_MIN);
		send_item(31'h7FFF_FFFF, WORD_MAX, WORD_MIN, WORD_MIN);
		drain();
	endtask

	task automatic test_backpressure();
		word_t nc [4];
		word_t dc [4];
		nc = '{COEF_ONE, 32'sh0000_8000, 32'sd0, 32'sd0};
		dc = '{COEF_ONE, COEF_ONE, 32'sh0000_4000, 32'sd0};
		load_coefs(nc, dc);
		hold_len = 300;
		for (int i = 0; i < 120; i++)
			send_item(rand_omega(), rand_word(), rand_word(), rand_word());
		drain();
	endtask

	task automatic test_random(input int n_items);
		word_t nc [4];
		word_t dc [4];
		for (int phase = 0; phase < 8; phase++) begin
			for (int k = 0; k < 4; k++) begin
				nc[k] = rand_word();
				dc[k] = rand_word();
			end
			if (phase == 0) begin
				nc = '{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};
				dc = '{WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX};
			end
			load_coefs(nc, dc);
			quiet = (phase == 3);
			for (int i = 0; i < n_items; i++) begin
				send_item(rand_omega(), rand_word(), word_t'($urandom), rand_word());
				if (i == n_items / 2 && phase == 5)
					drain();
			end
			quiet = 0;
			drain();
		end
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			out_ready <= quiet || $urandom_range(99) >= 14;
		end
	end

	// result check
	always @(negedge clk) begin
		resp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: re=%0d im=%0d", out_re, out_im);
			end else begin
				want = pending_resp.pop_front();
				if (out_re !== want.re || out_im !== want.im || div_zero !== want.dz ||
						saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want re=%0d im=%0d dz=%b sat=%b, got re=%0d im=%0d dz=%b sat=%b",
							want.re, want.im, want.dz, want.sat,
							out_re, out_im, div_zero, saturated);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		omega      = '0;
		in_re      = '0;
		in_im      = '0;
		gain       = '0;
		wr_en      = 1'b0;
		wr_idx     = '0;
		wr_data    = '0;
		mismatches = 0;
		quiet      = 0;
		hold_len   = 0;
		stall_cnt  = 0;
		for (int k = 0; k < NREG; k++)
			coef[k] = '0;
		coef[0]     = COEF_ONE;
		coef[NCOEF] = COEF_ONE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_coefs();
		test_backpressure();
		test_random(115);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && pending_resp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/rtfr_pkg.sv
rtl/rtfr_cfg.sv
rtl/rtfr_poly.sv
rtl/rtfr_quot.sv
rtl/rtfr_out.sv
rtl/rational_tf_freq_response.sv
rtl/rtfr_chk.sv
sim/rational_tf_freq_response_tb.sv
